// ----- sv/ppm_pkg.sv -----
package ppm_pkg;

    // Channel count and field widths
    localparam int CHANNELS   = 8;
    localparam int CH_W       = 3;
    localparam int SAMPLE_W   = 32;
    localparam int LEVEL_W    = 17;
    localparam int STEP_W     = 19;
    localparam int COUNT_W    = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    // Level at or above which the clip indicator is reloaded
    localparam logic [LEVEL_W-1:0] CLIP_THRESHOLD = 17'h0FFF0;

    // Sample width codes
    localparam logic [1:0] WIDTH_8    = 2'd0;
    localparam logic [1:0] WIDTH_16   = 2'd1;
    localparam logic [1:0] WIDTH_32   = 2'd2;
    localparam logic [1:0] WIDTH_NONE = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_SIGNED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_CODE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_STEP    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_HOLD     = 2'd3;

    // Reset values of the configuration registers
    localparam logic [STEP_W-1:0]  DECAY_STEP_RESET = 19'd9;
    localparam logic [COUNT_W-1:0] CLIP_HOLD_RESET  = 20'd48000;

    typedef struct packed {
        logic               sample_signed;
        logic [1:0]         width_code;
        logic [STEP_W-1:0]  decay_step;
        logic [COUNT_W-1:0] clip_hold;
    } cfg_t;

    // One item between the input register and the meter update
    typedef struct packed {
        logic [CH_W-1:0]    channel;
        logic [LEVEL_W-1:0] mag;
        logic               skip;
    } stage_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               clipping;
    } result_t;

endpackage

// ----- sv/ppm_in_if.sv -----
interface ppm_in_if import ppm_pkg::*;;
    logic                valid;
    logic                ready;
    logic [CH_W-1:0]     channel;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output channel, output sample, input ready);
    modport sink (input valid, input channel, input sample, output ready);
endinterface

// ----- sv/ppm_out_if.sv -----
interface ppm_out_if import ppm_pkg::*;;
    logic               valid;
    logic               ready;
    logic [CH_W-1:0]    out_channel;
    logic [LEVEL_W-1:0] level;
    logic               clipping;

    modport source (output valid, output out_channel, output level, output clipping,
                    input ready);
    modport sink (input valid, input out_channel, input level, input clipping,
                  output ready);
endinterface

// ----- sv/ppm_cfg_if.sv -----
interface ppm_cfg_if import ppm_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- sv/ppm_cfg_regs.sv -----
module ppm_cfg_regs import ppm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    ppm_cfg_if.sink   cfg,
    output cfg_t      cfg_q
);

    cfg_t cfg_reg;

    // Writes are always taken.
    assign cfg.ready = 1'b1;
    assign cfg_q     = cfg_reg;

    // Register file, one register per transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sample_signed <= 1'b1;
            cfg_reg.width_code    <= WIDTH_16;
            cfg_reg.decay_step    <= DECAY_STEP_RESET;
            cfg_reg.clip_hold     <= CLIP_HOLD_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_SAMPLE_SIGNED: cfg_reg.sample_signed <= cfg.data[0];
                REG_WIDTH_CODE:    cfg_reg.width_code    <= cfg.data[1:0];
                REG_DECAY_STEP:    cfg_reg.decay_step    <= cfg.data[STEP_W-1:0];
                REG_CLIP_HOLD:     cfg_reg.clip_hold     <= cfg.data[COUNT_W-1:0];
            endcase
        end
    end

endmodule

// ----- sv/ppm_magnitude.sv -----
module ppm_magnitude import ppm_pkg::*;
(
    input  cfg_t                cfg_q,
    input  logic [SAMPLE_W-1:0] sample,
    output logic [LEVEL_W-1:0]  mag
);

    logic [7:0]  v8;
    logic [15:0] v16;
    logic [31:0] v32;
    logic [8:0]  m8;
    logic [16:0] m16;
    logic [32:0] m32;

    // Offset-binary samples become two's complement by flipping the top bit.
    always_comb
    begin
        v8  = sample[7:0]  ^ {~cfg_q.sample_signed, 7'b0};
        v16 = sample[15:0] ^ {~cfg_q.sample_signed, 15'b0};
        v32 = sample[31:0] ^ {~cfg_q.sample_signed, 31'b0};
    end

    // Absolute values, one bit wider so the most negative value fits.
    always_comb
    begin
        m8  = v8[7]   ? (9'h100 - {1'b0, v8})             : {1'b0, v8};
        m16 = v16[15] ? (17'h10000 - {1'b0, v16})         : {1'b0, v16};
        m32 = v32[31] ? (33'h100000000 - {1'b0, v32})     : {1'b0, v32};
    end

    // Scale each format to the common 0 to 65536 range.
    always_comb
    begin
        unique case (cfg_q.width_code)
            WIDTH_8:    mag = {m8[7:0], 9'b0};
            WIDTH_16:   mag = {m16[15:0], 1'b0};
            WIDTH_32:   mag = m32[31:15];
            WIDTH_NONE: mag = '0;
        endcase
    end

endmodule

// ----- sv/ppm_meter_core.sv -----
module ppm_meter_core import ppm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg_q,
    input  stage_t  item,
    input  logic    commit,
    output result_t result
);

    logic [LEVEL_W-1:0] level_reg [CHANNELS];
    logic [COUNT_W-1:0] count_reg [CHANNELS];

    logic               ch_valid;
    logic               do_update;
    logic [LEVEL_W-1:0] level_cur;
    logic [COUNT_W-1:0] count_cur;
    logic [LEVEL_W-1:0] level_next;
    logic [COUNT_W-1:0] count_next;

    assign ch_valid  = 32'(item.channel) < CHANNELS;
    assign do_update = commit && ch_valid && !item.skip;

    // Read the addressed channel's meter state.
    always_comb
    begin
        level_cur = '0;
        count_cur = '0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            if (32'(item.channel) == i)
            begin
                level_cur = level_reg[i];
                count_cur = count_reg[i];
            end
        end
    end

    // Peak hold with linear decay, then the clip-hold countdown.
    always_comb
    begin
        priority if (level_cur < item.mag)
            level_next = item.mag;
        else if ({2'b0, level_cur} >= cfg_q.decay_step)
            level_next = level_cur - cfg_q.decay_step[LEVEL_W-1:0];
        else
            level_next = '0;

        priority if (level_next >= CLIP_THRESHOLD)
            count_next = cfg_q.clip_hold;
        else if (count_cur != '0)
            count_next = count_cur - 1'b1;
        else
            count_next = count_cur;
    end

    // Result: unknown channels read as zero, an unusable format leaves the state.
    always_comb
    begin
        priority if (!ch_valid)
        begin
            result.level    = '0;
            result.clipping = 1'b0;
        end
        else if (item.skip)
        begin
            result.level    = level_cur;
            result.clipping = count_cur != '0;
        end
        else
        begin
            result.level    = level_next;
            result.clipping = count_next != '0;
        end
    end

    // Per-channel state write-back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                level_reg[i] <= '0;
                count_reg[i] <= '0;
            end
        end
        else if (do_update)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                if (32'(item.channel) == i)
                begin
                    level_reg[i] <= level_next;
                    count_reg[i] <= count_next;
                end
            end
        end
    end

endmodule

// ----- sv/pcm_peak_level_meter.sv -----
// A sample is held in the input register and then in the result register; while the result
// register is full and not drained, the input register holds its sample and samples.ready falls.
// Throughput: one sample per cycle while the output is not stalled; the per-channel state
// is read, updated and written back between the input register and the result register.
// Reset (rst_n, asynchronous, active low) clears all levels and clip counters and loads the
// format, decay and clip-hold registers with their defaults; no clearing pass is needed.
module pcm_peak_level_meter import ppm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    ppm_cfg_if.sink    cfg,
    ppm_in_if.sink     samples,
    ppm_out_if.source  meters
);

    cfg_t               cfg_q;
    logic [LEVEL_W-1:0] mag;
    stage_t             stage_next;
    stage_t             stage_reg;
    logic               stage_valid_reg;
    logic               out_valid_reg;
    logic [CH_W-1:0]    out_channel_reg;
    result_t            out_reg;
    result_t            result;
    logic               advance;
    logic               commit;
    logic               take;

    ppm_cfg_regs u_cfg_regs
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    ppm_magnitude u_magnitude
    (
        .cfg_q  (cfg_q),
        .sample (samples.sample),
        .mag    (mag)
    );

    ppm_meter_core u_meter_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_q  (cfg_q),
        .item   (stage_reg),
        .commit (commit),
        .result (result)
    );

    // Handshake: the pipeline moves whenever the result register is free or drained.
    assign advance       = !out_valid_reg || meters.ready;
    assign commit        = advance && stage_valid_reg;
    assign samples.ready = advance || !stage_valid_reg;
    assign take          = samples.valid && samples.ready;

    always_comb
    begin
        stage_next.channel = samples.channel;
        stage_next.mag     = mag;
        stage_next.skip    = cfg_q.width_code == WIDTH_NONE;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else if (samples.ready)
            stage_valid_reg <= samples.valid;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            stage_reg <= stage_next;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= stage_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_channel_reg <= stage_reg.channel;
            out_reg         <= result;
        end
    end

    assign meters.valid       = out_valid_reg;
    assign meters.out_channel = out_channel_reg;
    assign meters.level       = out_reg.level;
    assign meters.clipping    = out_reg.clipping;

endmodule
